// ===== rtl/script_token_classifier_unit_defines.svh =====
// assertion macros for the script token classifier
// used by script_token_classifier_unit, expects clk and arst_n in scope
`ifndef SCRIPT_TOKEN_CLASSIFIER_UNIT_DEFINES_SVH
`define SCRIPT_TOKEN_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define STC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define STC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/stc_pkg.sv =====
// types, codes and character constants of the script token classifier
// no dependencies
`timescale 1ns / 1ps

package stc_pkg;

	typedef enum logic [2:0] {
		M_IDLE,
		M_COMMENT,
		M_STRING,
		M_ESCAPE,
		M_WORD,
		M_NAME
	} mode_t;

	typedef enum logic [2:0] {
		N_START,
		N_SIGN,
		N_INT,
		N_FRAC,
		N_EXP,
		N_EXPDIG,
		N_BAD
	} num_t;

	typedef enum logic [1:0] {
		NK_PLAIN,
		NK_INCLUDE,
		NK_MACRO
	} name_kind_t;

	localparam logic [3:0] K_COMMA     = 4'd0;
	localparam logic [3:0] K_SEMICOLON = 4'd1;
	localparam logic [3:0] K_OPEN      = 4'd2;
	localparam logic [3:0] K_CLOSE     = 4'd3;
	localparam logic [3:0] K_STRING    = 4'd4;
	localparam logic [3:0] K_WORD      = 4'd5;
	localparam logic [3:0] K_INTEGER   = 4'd6;
	localparam logic [3:0] K_REAL      = 4'd7;
	localparam logic [3:0] K_END       = 4'd8;
	localparam logic [3:0] K_INCLUDE   = 4'd9;
	localparam logic [3:0] K_MACRO     = 4'd10;

	localparam logic [2:0] E_NONE       = 3'd0;
	localparam logic [2:0] E_EMPTY_STR  = 3'd1;
	localparam logic [2:0] E_UNFINISHED = 3'd2;
	localparam logic [2:0] E_TOO_LONG   = 3'd3;
	localparam logic [2:0] E_EMPTY_NAME = 3'd4;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		logic [3:0]  kind;
		logic [2:0]  err;
		logic [11:0] len;
		logic [23:0] line;
	} res_t;

	typedef struct packed {
		logic any;
		logic two;
		res_t r0;
		res_t r1;
	} step_t;

	function automatic num_t dfa_next(input num_t s, input logic [7:0] c);
		logic d;
		logic sg;
		num_t r;
		d  = (c >= CH_0) && (c <= CH_9);
		sg = (c == CH_PLUS) || (c == CH_MINUS);
		case (s)
			N_START: begin
				r = sg ? N_SIGN : d ? N_INT : (c == CH_DOT) ? N_FRAC : N_BAD;
			end
			N_SIGN, N_INT: begin
				r = d ? N_INT : (c == CH_DOT) ? N_FRAC : N_BAD;
			end
			N_FRAC: begin
				r = d ? N_FRAC : ((c == CH_LO_E) || (c == CH_UP_E)) ? N_EXP : N_BAD;
			end
			N_EXP: begin
				r = (d || sg) ? N_EXPDIG : N_BAD;
			end
			N_EXPDIG: begin
				r = d ? N_EXPDIG : N_BAD;
			end
			default: begin
				r = N_BAD;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/stc_lex_core.sv =====
// lexer state and per-character step logic, up to two results per character
// depends on stc_pkg
`timescale 1ns / 1ps

module stc_lex_core import stc_pkg::*; #(
	parameter int MAX_TOKEN = 2048,
	parameter int LINE_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] c,
	input  logic       eoi,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	output step_t      step
);

	localparam int CNT_W = $clog2(MAX_TOKEN + 1);
	localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_TOKEN);

	mode_t                mode_q, mode_nx;
	num_t                 num_q, num_nx;
	name_kind_t           name_q, name_nx;
	logic [CNT_W-1:0]     cnt_q, cnt_nx;
	logic                 tl_q, tl_nx;
	logic [LINE_BITS-1:0] line_q;
	logic                 numen_q;
	logic                 inc_line;

	logic [CNT_W+11:0]     cnt_ext;
	logic [LINE_BITS+23:0] line_ext;
	logic [11:0]           len_out;
	logic [23:0]           line_out;
	res_t                  word_res, name_res;
	res_t                  tok, sec;
	logic                  tok_v, sec_v;

	assign cnt_ext  = {12'b0, cnt_q};
	assign line_ext = {24'b0, line_q};
	assign len_out  = cnt_ext[11:0];
	assign line_out = line_ext[23:0];

	always_comb begin
		word_res      = '0;
		word_res.len  = len_out;
		word_res.line = line_out;
		word_res.kind = K_WORD;
		word_res.err  = E_NONE;
		if (tl_q) begin
			word_res.err = E_TOO_LONG;
		end else if (numen_q) begin
			if (num_q == N_INT) begin
				word_res.kind = K_INTEGER;
			end else if (num_q == N_FRAC || num_q == N_EXP || num_q == N_EXPDIG) begin
				word_res.kind = K_REAL;
			end
		end
	end

	always_comb begin
		name_res      = '0;
		name_res.len  = len_out;
		name_res.line = line_out;
		name_res.kind = (name_q == NK_MACRO) ? K_MACRO : K_INCLUDE;
		name_res.err  = (cnt_q == '0) ? E_EMPTY_NAME : tl_q ? E_TOO_LONG : E_NONE;
	end

	always_comb begin
		logic do_idle;
		logic do_append;
		logic track;
		mode_nx   = mode_q;
		num_nx    = num_q;
		cnt_nx    = cnt_q;
		name_nx   = name_q;
		tl_nx     = tl_q;
		inc_line  = 1'b0;
		tok_v     = 1'b0;
		sec_v     = 1'b0;
		tok       = '0;
		sec       = '0;
		do_idle   = 1'b0;
		do_append = 1'b0;
		track     = 1'b0;
		if (eoi) begin
			case (mode_q)
				M_WORD: begin
					tok_v = 1'b1;
					tok   = word_res;
				end
				M_NAME: begin
					tok_v = 1'b1;
					tok   = name_res;
				end
				M_STRING, M_ESCAPE: begin
					tok_v    = 1'b1;
					tok.kind = K_STRING;
					tok.err  = E_UNFINISHED;
					tok.len  = len_out;
				end
				default: begin
				end
			endcase
			mode_nx  = M_IDLE;
			sec_v    = 1'b1;
			sec.kind = K_END;
		end else begin
			case (mode_q)
				M_COMMENT: begin
					if (c == CH_NL) begin
						inc_line = 1'b1;
						mode_nx  = M_IDLE;
					end
				end
				M_STRING: begin
					if (c == CH_QUOTE) begin
						tok_v    = 1'b1;
						tok.kind = K_STRING;
						tok.err  = (cnt_q == '0) ? E_EMPTY_STR : tl_q ? E_TOO_LONG : E_NONE;
						tok.len  = len_out;
						mode_nx  = M_IDLE;
					end else if (c == CH_NL) begin
						tok_v    = 1'b1;
						tok.kind = K_STRING;
						tok.err  = E_UNFINISHED;
						tok.len  = len_out;
						inc_line = 1'b1;
						mode_nx  = M_IDLE;
					end else if (c == CH_BSLASH) begin
						mode_nx = M_ESCAPE;
					end else begin
						do_append = 1'b1;
					end
				end
				M_ESCAPE: begin
					if (c == CH_NL) begin
						tok_v    = 1'b1;
						tok.kind = K_STRING;
						tok.err  = E_UNFINISHED;
						tok.len  = len_out;
						inc_line = 1'b1;
						mode_nx  = M_IDLE;
					end else begin
						do_append = 1'b1;
						mode_nx   = M_STRING;
					end
				end
				M_WORD, M_NAME: begin
					if (c inside {CH_SP, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR,
					              CH_COMMA, CH_SEMI, CH_LBRACE, CH_RBRACE}) begin
						tok_v   = 1'b1;
						tok     = (mode_q == M_WORD) ? word_res : name_res;
						mode_nx = M_IDLE;
						do_idle = 1'b1;
					end else begin
						do_append = 1'b1;
						track     = (mode_q == M_WORD);
					end
				end
				default: begin
					mode_nx = M_IDLE;
					do_idle = 1'b1;
				end
			endcase
			if (do_append) begin
				if (cnt_q < MAXC) begin
					cnt_nx = CNT_W'(cnt_q + 1'b1);
					if (track) begin
						num_nx = dfa_next(num_q, c);
					end
				end else begin
					tl_nx = 1'b1;
				end
			end
			if (do_idle) begin
				case (c)
					CH_NL: begin
						inc_line = 1'b1;
					end
					CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR: begin
					end
					CH_BANG: begin
						mode_nx = M_COMMENT;
					end
					CH_COMMA: begin
						sec_v    = 1'b1;
						sec.kind = K_COMMA;
						sec.len  = 12'd1;
					end
					CH_SEMI: begin
						sec_v    = 1'b1;
						sec.kind = K_SEMICOLON;
						sec.len  = 12'd1;
					end
					CH_LBRACE: begin
						sec_v    = 1'b1;
						sec.kind = K_OPEN;
						sec.len  = 12'd1;
					end
					CH_RBRACE: begin
						sec_v    = 1'b1;
						sec.kind = K_CLOSE;
						sec.len  = 12'd1;
					end
					CH_QUOTE: begin
						mode_nx = M_STRING;
						name_nx = NK_PLAIN;
						cnt_nx  = '0;
						num_nx  = N_START;
						tl_nx   = 1'b0;
					end
					CH_AT: begin
						mode_nx = M_NAME;
						name_nx = NK_INCLUDE;
						cnt_nx  = '0;
						num_nx  = N_START;
						tl_nx   = 1'b0;
					end
					CH_DOLLAR: begin
						mode_nx = M_NAME;
						name_nx = NK_MACRO;
						cnt_nx  = '0;
						num_nx  = N_START;
						tl_nx   = 1'b0;
					end
					default: begin
						mode_nx = M_WORD;
						name_nx = NK_PLAIN;
						cnt_nx  = CNT_W'(1);
						num_nx  = dfa_next(N_START, c);
						tl_nx   = 1'b0;
					end
				endcase
			end
		end
		tok.line = line_out;
		sec.line = line_out;
	end

	assign step.any = en && (tok_v || sec_v);
	assign step.two = tok_v && sec_v;
	assign step.r0  = tok_v ? tok : sec;
	assign step.r1  = sec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			num_q   <= N_START;
			name_q  <= NK_PLAIN;
			cnt_q   <= '0;
			tl_q    <= 1'b0;
			line_q  <= LINE_BITS'(1);
			numen_q <= 1'b1;
		end else begin
			if (en) begin
				mode_q <= mode_nx;
				num_q  <= num_nx;
				name_q <= name_nx;
				cnt_q  <= cnt_nx;
				tl_q   <= tl_nx;
				if (inc_line && (line_q != '1)) begin
					line_q <= LINE_BITS'(line_q + 1'b1);
				end
			end
			if (cfg_we) begin
				numen_q <= cfg_wdata;
			end
		end
	end

endmodule

// ===== rtl/script_token_classifier_unit.sv =====
// script token classifier: byte stream in, one token request per result out
// input register, stc_lex_core step logic and a two-slot result register
// depends on stc_pkg, stc_lex_core and script_token_classifier_unit_defines.svh
//
// usage
//   s_tdata carries one character per request; s_tlast marks end of input,
//   which closes a pending token and adds an end token (kind 8).
//   each character yields zero, one or two result requests on the m_ side;
//   m_tlast flags the last result caused by that character.
//   cfg_we/cfg_wdata write numbers_enabled (reset 1); write only while idle.
// data path and throughput
//   a character is held in the input register, then its results are loaded
//   into the result register that drives m_tvalid. one character per cycle
//   while m_tready is high; a character with two results holds the result
//   register until both are taken, which sets the rate for such characters.
// reset
//   arst_n clears all control state; line count restarts at one, lexer idle.
// stall
//   while m_tready is low the result register holds, the input register
//   fills, and s_tready drops once both are occupied. nothing is dropped.
`timescale 1ns / 1ps
`include "script_token_classifier_unit_defines.svh"

module script_token_classifier_unit import stc_pkg::*; #(
	parameter int MAX_TOKEN = 2048,
	parameter int LINE_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_in
	input  logic        s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // error_code, token_length, line count, zero pad
	output logic [3:0]  m_tuser,   // token_kind
	output logic        m_tlast,   // last_result
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	logic  pv_q;
	logic  sel_q;
	logic  two_q;
	res_t  r0_q;
	res_t  r1_q;
	res_t  cur;
	step_t step;

	logic drain_done;
	logic pair_free;
	logic adv;

	assign drain_done = pv_q && m_tready && (sel_q || !two_q);
	assign pair_free  = !pv_q || drain_done;
	assign adv        = valid_s1 && pair_free;
	assign s_tready   = !valid_s1 || adv;

	stc_lex_core #(
		.MAX_TOKEN (MAX_TOKEN),
		.LINE_BITS (LINE_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.c         (byte_s1),
		.eoi       (eoi_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	// result register, two slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= 1'b0;
			sel_q <= 1'b0;
			two_q <= 1'b0;
		end else if (adv && step.any) begin
			pv_q  <= 1'b1;
			sel_q <= 1'b0;
			two_q <= step.two;
		end else if (drain_done) begin
			pv_q  <= 1'b0;
			sel_q <= 1'b0;
		end else if (pv_q && m_tready) begin
			sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step.any) begin
			r0_q <= step.r0;
			r1_q <= step.r1;
		end
	end

	assign cur      = sel_q ? r1_q : r0_q;
	assign m_tvalid = pv_q;
	assign m_tdata  = {1'b0, cur.line, cur.len, cur.err};
	assign m_tuser  = cur.kind;
	assign m_tlast  = sel_q || !two_q;

	`STC_ASSERT_IMP(a_sel_needs_two, pv_q && sel_q, two_q, "second slot without pair")
	`STC_ASSERT_NXT(a_second_kept, pv_q && m_tready && two_q && !sel_q, pv_q && sel_q, "lost")
	`STC_ASSERT_NXT(a_load_shows, adv && step.any, pv_q && !sel_q, "loaded result not shown")
	`STC_ASSERT_IMP(a_end_shape, m_tvalid && m_tuser == K_END, m_tdata[14:0] == '0 && m_tlast, "end")

endmodule
